### rtl/core/fsq_pkg.sv
// Shared types, constants and register indexes of the FSQ code splitter.
package fsq_pkg;

	// Field and register widths.
	localparam int CODE_W     = 32;
	localparam int LEVEL_W    = 8;
	localparam int DIMS_W     = 3;
	localparam int SCALE_W    = 17;
	localparam int FRAC_BITS  = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Dimension limits and register reset values.
	localparam int MAX_DIMS_LIMIT = 6;
	localparam int DEF_MAX_DIMS   = 6;
	localparam logic [DIMS_W-1:0] NUM_DIMS_RESET = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET [MAX_DIMS_LIMIT] =
		'{8'd8, 8'd5, 8'd5, 8'd5, 8'd2, 8'd2};

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
	localparam int                   REG_LEVEL_BASE = 1;

	// Codebook size is held saturated at two to the power of the code width.
	localparam int PROD_W = CODE_W + 1;
	localparam logic [PROD_W-1:0] PROD_CAP = {1'b1, {CODE_W{1'b0}}};

	// Divider: quotient bits resolved per cycle.
	localparam int BITS_PER_STEP = 8;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// One classified code travelling from the front to the back.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              oor;
	} queue_entry_t;

endpackage

### rtl/core/fsq_div.sv
// Iterative unsigned divider resolving several quotient bits per cycle.
module fsq_div import fsq_pkg::*; #(
	parameter int DIVIDEND_W = CODE_W,
	parameter int DIVISOR_W  = LEVEL_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int STEPS  = (DIVIDEND_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD_W  = STEPS * BITS_PER_STEP;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_RUN  = 3'b010,
		DIV_DONE = 3'b100
	} div_state_t;

	div_state_t           state_q;
	logic [STEP_W-1:0]    cnt_q;
	logic [PAD_W-1:0]     work_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W-1:0] rem_nx;
	logic [PAD_W-1:0]     work_nx;

	// One step of restoring division: dividend bits shift out at the top,
	// quotient bits shift in at the bottom.
	always_comb begin
		trial   = '0;
		rem_nx  = rem_q;
		work_nx = work_q;
		for (int j = 0; j < BITS_PER_STEP; j++) begin
			trial   = {rem_nx, work_nx[PAD_W-1]};
			work_nx = {work_nx[PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor_q}) begin
				trial      = trial - {1'b0, divisor_q};
				work_nx[0] = 1'b1;
			end
			rem_nx = trial[DIVISOR_W-1:0];
		end
	end

	// Control sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				DIV_IDLE: begin
					if (in_valid) begin
						state_q <= DIV_RUN;
						cnt_q   <= STEP_W'(STEPS - 1);
					end
				end
				DIV_RUN: begin
					if (cnt_q == '0) begin
						state_q <= DIV_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				DIV_DONE: begin
					if (out_ready) begin
						state_q <= DIV_IDLE;
					end
				end
				default: begin
					state_q <= DIV_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && in_valid) begin
			work_q    <= PAD_W'(dividend);
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (state_q == DIV_RUN) begin
			work_q <= work_nx;
			rem_q  <= rem_nx;
		end
	end

	assign in_ready  = (state_q == DIV_IDLE);
	assign out_valid = (state_q == DIV_DONE);
	assign quotient  = work_q[DIVIDEND_W-1:0];
	assign remainder = rem_q;

endmodule

### rtl/core/fsq_fifo.sv
// Short queue of classified codes between the front and the back.
module fsq_fifo import fsq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  queue_entry_t push_entry,
	output logic         pop_valid,
	input  logic         pop_ready,
	output queue_entry_t pop_entry
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	queue_entry_t     entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### rtl/core/fsq_front.sv
// Front: keeps the codebook size up to date and classifies incoming codes.
module fsq_front import fsq_pkg::*; #(
	parameter int MAX_DIMS = DEF_MAX_DIMS,
	parameter int DIM_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_changed,
	input  logic [LEVEL_W-1:0]       levels [MAX_DIMS],
	input  logic [DIM_W-1:0]         last_dim,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CODE_W-1:0] code,
	output logic                     push_valid,
	input  logic                     push_ready,
	output queue_entry_t             push_entry
);

	localparam int MULT_W = PROD_W + LEVEL_W;

	logic               busy_q;
	logic [DIM_W-1:0]   step_q;
	logic [PROD_W-1:0]  prod_q;
	logic [LEVEL_W-1:0] lvl_sel;
	logic [MULT_W-1:0]  mult;

	// Level count of the dimension being folded into the product.
	always_comb begin
		lvl_sel = levels[0];
		for (int i = 0; i < MAX_DIMS; i++) begin
			if (step_q == DIM_W'(i)) begin
				lvl_sel = levels[i];
			end
		end
	end

	assign mult = MULT_W'(prod_q) * MULT_W'(lvl_sel);

	// Codebook size, rebuilt one dimension at a time after reset and after
	// every register write, saturating at the cap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			step_q <= '0;
			prod_q <= PROD_W'(1);
		end else if (cfg_changed) begin
			busy_q <= 1'b1;
			step_q <= '0;
			prod_q <= PROD_W'(1);
		end else if (busy_q) begin
			if (step_q <= last_dim) begin
				prod_q <= (mult > MULT_W'(PROD_CAP)) ? PROD_CAP : mult[PROD_W-1:0];
			end
			if (step_q == DIM_W'(MAX_DIMS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Classification: negative codes and codes at or above the size are errors.
	assign in_ready        = !busy_q && push_ready;
	assign push_valid      = in_valid && !busy_q;
	assign push_entry.code = code;
	assign push_entry.oor  = code[CODE_W-1] || ({1'b0, $unsigned(code)} >= prod_q);

endmodule

### rtl/core/fsq_back.sv
// Back: splits each code into digits, scales them and drives the result port.
module fsq_back import fsq_pkg::*; #(
	parameter int MAX_DIMS = DEF_MAX_DIMS,
	parameter int DIM_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [LEVEL_W-1:0]        levels [MAX_DIMS],
	input  logic [DIM_W-1:0]          last_dim,
	input  logic                      pop_valid,
	output logic                      pop_ready,
	input  queue_entry_t              pop_entry,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [DIMS_W-1:0]         dim_index,
	output logic [LEVEL_W-1:0]        digit,
	output logic signed [SCALE_W-1:0] scaled_value,
	output logic                      last,
	output logic                      out_of_range
);

	localparam int SDIV_W = LEVEL_W + FRAC_BITS + 1;

	// Digit stage.
	logic              a_busy_q;
	logic              a_issued_q;
	logic [CODE_W-1:0] a_rem_q;
	logic [DIM_W-1:0]  a_k_q;

	// Scaling stage.
	logic               b_full_q;
	logic               b_issued_q;
	logic               b_err_q;
	logic [DIM_W-1:0]   b_k_q;
	logic [LEVEL_W-1:0] b_digit_q;
	logic [LEVEL_W-1:0] b_mag_q;
	logic               b_neg_q;
	logic [LEVEL_W-1:0] b_den_q;
	logic               b_last_q;

	// Output register.
	logic                      out_valid_q;
	logic [DIMS_W-1:0]         dim_index_q;
	logic [LEVEL_W-1:0]        digit_q;
	logic signed [SCALE_W-1:0] scaled_value_q;
	logic                      last_q;
	logic                      out_of_range_q;

	logic                      dd_in_valid;
	logic                      dd_in_ready;
	logic                      dd_out_valid;
	logic [CODE_W-1:0]         dd_quo;
	logic [LEVEL_W-1:0]        dd_rem;
	logic                      sd_in_valid;
	logic                      sd_in_ready;
	logic                      sd_out_valid;
	logic [SDIV_W-1:0]         sd_dividend;
	logic [SDIV_W-1:0]         sd_quo;
	logic [LEVEL_W:0]          sd_rem;
	logic [LEVEL_W-1:0]        lvl_sel;
	logic [LEVEL_W-1:0]        den_sel;
	logic signed [LEVEL_W+1:0] diff;
	logic [LEVEL_W+1:0]        diff_abs;
	logic                      a_last;
	logic                      a_xfer;
	logic                      pop_take;
	logic                      err_take;
	logic                      out_free;
	logic                      b_done;
	logic                      out_load;
	logic signed [SCALE_W-1:0] sd_mag;

	// Level count of the dimension under division.
	always_comb begin
		lvl_sel = levels[0];
		for (int i = 0; i < MAX_DIMS; i++) begin
			if (a_k_q == DIM_W'(i)) begin
				lvl_sel = levels[i];
			end
		end
	end

	assign den_sel = lvl_sel - 1'b1;
	assign a_last  = (a_k_q == last_dim);

	// Signed distance of twice the digit from the top level.
	assign diff     = $signed({1'b0, dd_rem, 1'b0}) - $signed({2'b00, den_sel});
	assign diff_abs = diff[LEVEL_W+1] ? $unsigned(-diff) : $unsigned(diff);

	// Handshakes between the stages.
	assign out_free    = !out_valid_q || out_ready;
	assign a_xfer      = dd_out_valid && !b_full_q;
	assign pop_ready   = !a_busy_q && (!pop_entry.oor || !b_full_q);
	assign pop_take    = pop_valid && pop_ready && !pop_entry.oor;
	assign err_take    = pop_valid && pop_ready && pop_entry.oor;
	assign dd_in_valid = a_busy_q && !a_issued_q;
	assign sd_in_valid = b_full_q && !b_err_q && !b_issued_q;
	assign b_done      = b_full_q && (b_err_q || sd_out_valid);
	assign out_load    = b_done && out_free;

	// Digit divider: remainder by the level count of the current dimension.
	fsq_div #(
		.DIVIDEND_W(CODE_W),
		.DIVISOR_W (LEVEL_W)
	) u_digit_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dd_in_valid),
		.in_ready (dd_in_ready),
		.dividend (a_rem_q),
		.divisor  (lvl_sel),
		.out_valid(dd_out_valid),
		.out_ready(!b_full_q),
		.quotient (dd_quo),
		.remainder(dd_rem)
	);

	// Scaling divider: rounded |2d - (L-1)| * 32768 / (L-1).
	assign sd_dividend = (SDIV_W'(b_mag_q) << (FRAC_BITS + 1)) | SDIV_W'(b_den_q);

	fsq_div #(
		.DIVIDEND_W(SDIV_W),
		.DIVISOR_W (LEVEL_W + 1)
	) u_scale_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sd_in_valid),
		.in_ready (sd_in_ready),
		.dividend (sd_dividend),
		.divisor  ({b_den_q, 1'b0}),
		.out_valid(sd_out_valid),
		.out_ready(out_free),
		.quotient (sd_quo),
		.remainder(sd_rem)
	);

	assign sd_mag = sd_quo[SCALE_W-1:0];

	// Digit stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_busy_q   <= 1'b0;
			a_issued_q <= 1'b0;
			a_k_q      <= '0;
		end else begin
			if (pop_take) begin
				a_busy_q <= 1'b1;
				a_k_q    <= '0;
			end else if (a_xfer) begin
				a_issued_q <= 1'b0;
				a_k_q      <= a_k_q + 1'b1;
				if (a_last) begin
					a_busy_q <= 1'b0;
				end
			end else if (dd_in_valid && dd_in_ready) begin
				a_issued_q <= 1'b1;
			end
		end
	end

	// Running quotient of the code.
	always_ff @(posedge clk) begin
		if (pop_take) begin
			a_rem_q <= pop_entry.code;
		end else if (a_xfer) begin
			a_rem_q <= dd_quo;
		end
	end

	// Scaling stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_full_q   <= 1'b0;
			b_issued_q <= 1'b0;
			b_err_q    <= 1'b0;
		end else begin
			if (a_xfer || err_take) begin
				b_full_q   <= 1'b1;
				b_issued_q <= 1'b0;
				b_err_q    <= err_take;
			end else if (out_load) begin
				b_full_q   <= 1'b0;
				b_issued_q <= 1'b0;
			end else if (sd_in_valid && sd_in_ready) begin
				b_issued_q <= 1'b1;
			end
		end
	end

	// Scaling stage payload; an error transaction carries zeros and has last set.
	always_ff @(posedge clk) begin
		if (err_take) begin
			b_k_q     <= '0;
			b_digit_q <= '0;
			b_mag_q   <= '0;
			b_neg_q   <= 1'b0;
			b_den_q   <= '0;
			b_last_q  <= 1'b1;
		end else if (a_xfer) begin
			b_k_q     <= a_k_q;
			b_digit_q <= dd_rem;
			b_mag_q   <= diff_abs[LEVEL_W-1:0];
			b_neg_q   <= diff[LEVEL_W+1];
			b_den_q   <= den_sel;
			b_last_q  <= a_last;
		end
	end

	// Output register: holds a result while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dim_index_q    <= DIMS_W'(b_k_q);
			digit_q        <= b_digit_q;
			last_q         <= b_last_q;
			out_of_range_q <= b_err_q;
			if (b_err_q) begin
				scaled_value_q <= '0;
			end else begin
				scaled_value_q <= b_neg_q ? -sd_mag : sd_mag;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign dim_index    = dim_index_q;
	assign digit        = digit_q;
	assign scaled_value = scaled_value_q;
	assign last         = last_q;
	assign out_of_range = out_of_range_q;

endmodule

### rtl/core/fsq_code_to_levels_top.sv
// Top level of the FSQ code to levels splitter: registers, front, queue and back.
//
// Usage. One signed code enters per transaction on the input channel
// (in_valid, in_ready, code). For each code the result channel carries one
// transaction per dimension in use, dimension zero first, each with the
// mixed-radix digit and its value mapped to -1..1 in fixed point with 15
// fraction bits; the final one has last set. A negative code, or one not below
// the product of the level counts, gives a single transaction with
// out_of_range and last set and all other fields zero.
// Timing. The digit divider settles eight quotient bits a cycle, and the back
// takes the next code from the queue only once the digit stage has sent on
// the last dimension of the one before. The front takes a new code in the
// cycle after the previous one while the two-entry queue has room.
// Reset and configuration. After reset, and after every register write, the
// front rebuilds the codebook size one dimension at a time with in_ready low.
// When the receiver stalls, the output register holds its result and the
// back and queue fill up before in_ready drops.
module fsq_code_to_levels_top import fsq_pkg::*; #(
	parameter int MAX_DIMS = DEF_MAX_DIMS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [CODE_W-1:0]  code,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [DIMS_W-1:0]         dim_index,
	output logic [LEVEL_W-1:0]        digit,
	output logic signed [SCALE_W-1:0] scaled_value,
	output logic                      last,
	output logic                      out_of_range
);

	localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	logic [DIMS_W-1:0]  num_dims_q;
	logic [LEVEL_W-1:0] levels_q [MAX_DIMS];
	logic [LEVEL_W-1:0] wr_level;
	logic [DIMS_W-1:0]  dims_sat;
	logic [DIM_W-1:0]   last_dim;

	logic         push_valid;
	logic         push_ready;
	queue_entry_t push_entry;
	logic         pop_valid;
	logic         pop_ready;
	queue_entry_t pop_entry;

	// Level counts below two are stored as two.
	assign wr_level = (cfg_data[LEVEL_W-1:0] < LEVEL_MIN) ? LEVEL_MIN : cfg_data[LEVEL_W-1:0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= NUM_DIMS_RESET;
			for (int i = 0; i < MAX_DIMS; i++) begin
				levels_q[i] <= LEVEL_RESET[i];
			end
		end else if (cfg_write) begin
			if (cfg_index == REG_NUM_DIMS) begin
				num_dims_q <= cfg_data[DIMS_W-1:0];
			end
			for (int i = 0; i < MAX_DIMS; i++) begin
				if (cfg_index == CFG_IDX_W'(REG_LEVEL_BASE + i)) begin
					levels_q[i] <= wr_level;
				end
			end
		end
	end

	// Dimensions in use: zero counts as one, large counts saturate.
	always_comb begin
		if (num_dims_q == '0) begin
			dims_sat = DIMS_W'(1);
		end else if (num_dims_q > DIMS_W'(MAX_DIMS)) begin
			dims_sat = DIMS_W'(MAX_DIMS);
		end else begin
			dims_sat = num_dims_q;
		end
	end

	assign last_dim = DIM_W'(dims_sat - 1'b1);

	fsq_front #(
		.MAX_DIMS(MAX_DIMS),
		.DIM_W   (DIM_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_changed(cfg_write),
		.levels     (levels_q),
		.last_dim   (last_dim),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code       (code),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	fsq_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	fsq_back #(
		.MAX_DIMS(MAX_DIMS),
		.DIM_W   (DIM_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.levels      (levels_q),
		.last_dim    (last_dim),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_entry   (pop_entry),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dim_index   (dim_index),
		.digit       (digit),
		.scaled_value(scaled_value),
		.last        (last),
		.out_of_range(out_of_range)
	);

endmodule

### rtl/core/fsq_chk.sv
// Port-level checker for the FSQ splitter and its bind to the top level.
module fsq_chk import fsq_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [DIMS_W-1:0]         dim_index,
	input logic [LEVEL_W-1:0]        digit,
	input logic signed [SCALE_W-1:0] scaled_value,
	input logic                      last,
	input logic                      out_of_range
);

	logic [DIMS_W-1:0] exp_dim_q;

	// Dimension expected on the next result transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_dim_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_dim_q <= last ? '0 : dim_index + 1'b1;
		end
	end

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({dim_index, digit, scaled_value, last, out_of_range}))
		else $error("result changed while stalled");

	// Results of one code walk the dimensions in order from zero.
	a_dim_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dim_index == exp_dim_q)
		else $error("dimension out of sequence");

	// An error transaction stands alone and carries zeros.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> last && dim_index == '0 && digit == '0 &&
		scaled_value == '0)
		else $error("malformed out-of-range result");

	// Digit zero always maps to minus one.
	a_zero_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_of_range && digit == '0 |-> scaled_value == -17'sd32768)
		else $error("digit zero not scaled to minus one");

endmodule

bind fsq_code_to_levels_top fsq_chk u_fsq_chk (.*);
